// File: rtl/core/efpmd_pkg.sv
package efpmd_pkg;

  localparam int SECTIONS_DEF      = 64;
  localparam int WORDS_PER_SECTION = 4;
  localparam int PHYS_BYTES_DEF    = 256;

  localparam int WIN_START_W = 9;
  localparam int WIN_LEN_W   = 10;
  localparam int READ_IDX_W  = 9;
  localparam int SLOT_W      = 2;
  localparam int SECTION_W   = 7;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 10'd512;
  localparam logic [7:0]           HDR_END       = 8'hFF;
  localparam logic [4:0]           HDR_EXT_CODE  = 5'h0F;
  localparam logic [15:0]          WORD_ERASED   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_EXT    = 3'd1,
    PH_LOW    = 3'd2,
    PH_HIGH   = 3'd3,
    PH_ENDED  = 3'd4
  } phase_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } ctrl_state_t;

  typedef enum logic {
    REG_WIN_START = 1'b0,
    REG_WIN_LEN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic rd_capture;
    logic fetch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       found;
    logic [1:0] slot;
  } seek_t;

  // First word slot at or after the given one whose enable bit is clear.
  function automatic seek_t seek_word(input logic [3:0] enables, input logic [2:0] from);
    seek_t res;
    res.found = 1'b0;
    res.slot  = '0;
    for (int i = WORDS_PER_SECTION - 1; i >= 0; i--) begin
      if (3'(i) >= from && !enables[i]) begin
        res.found = 1'b1;
        res.slot  = SLOT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/efpmd_ctrl.sv
module efpmd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  efpmd_pkg::op_t     in_op,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output efpmd_pkg::ctrl_cmd_t cmd
);
  import efpmd_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_READ) state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    cmd            = '0;
    out_valid_nxt  = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
      end
      ST_FETCH: begin
        cmd.fetch     = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
    accept         = in_tvalid && in_tready;
    cmd.load       = accept && in_op == OP_LOAD;
    cmd.restart    = accept && in_op == OP_RESTART;
    cmd.rd_capture = accept && in_op == OP_READ;
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/core/efpmd_parser.sv
module efpmd_parser #(
  parameter int SECTIONS   = efpmd_pkg::SECTIONS_DEF,
  parameter int PHYS_BYTES = efpmd_pkg::PHYS_BYTES_DEF,
  parameter int IDX_W      = $clog2(SECTIONS * efpmd_pkg::WORDS_PER_SECTION)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efpmd_pkg::ctrl_cmd_t cmd,
  input  logic [7:0]           phys_byte,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_idx,
  output logic [15:0]          wr_data,
  output logic                 parse_ended
);
  import efpmd_pkg::*;

  localparam int CNT_W = $clog2(PHYS_BYTES + 1);

  phase_t               phase_r, phase_nxt;
  logic [SECTION_W-1:0] sec_r, sec_nxt;
  logic [3:0]           en_r, en_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [7:0]           low_r, low_nxt;
  logic [7:0]           hold_r, hold_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      sec_r   <= '0;
      en_r    <= '0;
      slot_r  <= '0;
      low_r   <= '0;
      hold_r  <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      sec_r   <= sec_nxt;
      en_r    <= en_nxt;
      slot_r  <= slot_nxt;
      low_r   <= low_nxt;
      hold_r  <= hold_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    logic                 start_go;
    logic [SECTION_W-1:0] start_sec;
    logic [3:0]           start_en;
    logic                 count_inc;
    seek_t                sk;
    phase_nxt = phase_r;
    sec_nxt   = sec_r;
    en_nxt    = en_r;
    slot_nxt  = slot_r;
    low_nxt   = low_r;
    hold_nxt  = hold_r;
    cnt_nxt   = cnt_r;
    start_go  = 1'b0;
    start_sec = '0;
    start_en  = '0;
    count_inc = 1'b0;
    sk        = '0;
    if (cmd.restart) begin
      phase_nxt = PH_HEADER;
      sec_nxt   = '0;
      en_nxt    = '0;
      slot_nxt  = '0;
      low_nxt   = '0;
      hold_nxt  = '0;
      cnt_nxt   = '0;
    end else if (cmd.load) begin
      case (phase_r)
        PH_HEADER: begin
          if (phys_byte == HDR_END) begin
            phase_nxt = PH_ENDED;
          end else begin
            count_inc = 1'b1;
            if (phys_byte[4:0] == HDR_EXT_CODE) begin
              hold_nxt  = phys_byte;
              phase_nxt = PH_EXT;
            end else begin
              start_go  = 1'b1;
              start_sec = {3'b000, phys_byte[7:4]};
              start_en  = phys_byte[3:0];
            end
          end
        end
        PH_EXT: begin
          count_inc = 1'b1;
          start_go  = 1'b1;
          start_sec = {phys_byte[7:4], hold_r[7:5]};
          start_en  = phys_byte[3:0];
        end
        PH_LOW: begin
          count_inc = 1'b1;
          low_nxt   = phys_byte;
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          count_inc = 1'b1;
          sk = seek_word(en_r, {1'b0, slot_r} + 3'd1);
          if (sk.found) begin
            slot_nxt  = sk.slot;
            phase_nxt = PH_LOW;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
        default: ;
      endcase
      if (start_go) begin
        sec_nxt  = start_sec;
        en_nxt   = start_en;
        slot_nxt = '0;
        phase_nxt = PH_HEADER;
        if ({1'b0, start_sec} < 8'(SECTIONS)) begin
          sk = seek_word(start_en, 3'd0);
          if (sk.found) begin
            slot_nxt  = sk.slot;
            phase_nxt = PH_LOW;
          end
        end
      end
      if (count_inc) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_nxt >= CNT_W'(PHYS_BYTES)) phase_nxt = PH_ENDED;
      end
    end
  end

  always_comb begin
    wr_en       = cmd.load && phase_r == PH_HIGH;
    wr_idx      = IDX_W'({sec_r, slot_r});
    wr_data     = {phys_byte, low_r};
    parse_ended = phase_r == PH_ENDED;
  end

endmodule

// File: rtl/core/efpmd_store.sv
module efpmd_store #(
  parameter int SECTIONS = efpmd_pkg::SECTIONS_DEF,
  parameter int IDX_W    = $clog2(SECTIONS * efpmd_pkg::WORDS_PER_SECTION)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efpmd_pkg::ctrl_cmd_t cmd,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [15:0]          wr_data,
  input  logic [IDX_W-1:0]     rd_idx,
  input  logic                 rd_hi,
  input  logic                 rd_oow,
  input  logic                 rd_ended,
  output logic [7:0]           out_data,
  output logic                 out_oow,
  output logic                 out_ended
);
  import efpmd_pkg::*;

  localparam int DEPTH = SECTIONS * WORDS_PER_SECTION;

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_hi_r, rd_oow_r, rd_ended_r;
  logic [15:0]      rd_word_r;
  logic             rd_valid_r;
  logic [15:0]      word;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (cmd.fetch) rd_word_r <= mem[rd_idx_r];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.restart) begin
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      rd_idx_r   <= rd_idx;
      rd_hi_r    <= rd_hi;
      rd_oow_r   <= rd_oow;
      rd_ended_r <= rd_ended;
    end
    if (cmd.fetch) rd_valid_r <= valid_r[rd_idx_r];
  end

  always_comb begin
    word      = rd_valid_r ? rd_word_r : WORD_ERASED;
    out_oow   = rd_oow_r;
    out_ended = rd_ended_r;
    if (rd_oow_r) begin
      out_data = '0;
    end else begin
      out_data = rd_hi_r ? word[15:8] : word[7:0];
    end
  end

endmodule

// File: rtl/core/efuse_packet_map_decoder.sv
// Efuse packet map decoder.
// The input stream carries one command word per handshake. in_tuser selects the
// operation: load one physical efuse byte into the packet parser, read one byte
// of the logical map, or restart, which clears the parser and the map to all ones.
// Loads and restarts produce no output word. A read produces one output word with
// the logical byte, an out-of-window flag and the parse-ended flag.
// The readable window is set through the APB port (window start at 0x0, window
// length at 0x4); write it only while the block is idle.
// Loads stream at one byte per cycle while no read is being fetched or held at the output.
// The word store is a RAM with a registered read; it is read in the cycle after the
// read is accepted, and the result is on the output from the cycle after that.
// The output holds its word until out_tready is seen; while it waits, in_tready
// stays low, and it rises again in the cycle the output word is taken.
// After reset, and after a restart, the parser expects a header and every map
// entry reads as 0xFF; each store entry has a valid bit cleared at once, so no
// clearing pass is needed. The window registers reset to start 0, length 512
// and are kept across a restart.
module efuse_packet_map_decoder #(
  parameter int SECTIONS   = efpmd_pkg::SECTIONS_DEF,
  parameter int PHYS_BYTES = efpmd_pkg::PHYS_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // phys_byte[7:0], read_index[16:8], zero[23:17]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // data[7:0]
  output logic [1:0]  out_tuser,  // out_of_window[0], parse_ended[1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import efpmd_pkg::*;

  localparam int IDX_W     = $clog2(SECTIONS * WORDS_PER_SECTION);
  localparam int MAP_BYTES = SECTIONS * WORDS_PER_SECTION * 2;
  localparam int SUM_W     = WIN_LEN_W + 1;

  logic [WIN_START_W-1:0] win_start_r, win_start_nxt;
  logic [WIN_LEN_W-1:0]   win_len_r, win_len_nxt;
  logic                   cfg_wr;
  reg_idx_t               cfg_reg;

  ctrl_cmd_t              cmd;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [15:0]            wr_data;
  logic                   parse_ended;
  logic [READ_IDX_W-1:0]  read_index;
  logic [WIN_LEN_W-1:0]   byte_addr;
  logic                   rd_oow;
  logic                   oow_flag;
  logic                   ended_flag;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_reg    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    win_start_nxt = win_start_r;
    win_len_nxt   = win_len_r;
    if (cfg_wr) begin
      case (cfg_reg)
        REG_WIN_START: win_start_nxt = cfg_pwdata[WIN_START_W-1:0];
        REG_WIN_LEN:   win_len_nxt   = cfg_pwdata[WIN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_len_r   <= WIN_LEN_RESET;
    end else begin
      win_start_r <= win_start_nxt;
      win_len_r   <= win_len_nxt;
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_WIN_START: cfg_prdata = {{(32 - WIN_START_W){1'b0}}, win_start_r};
      REG_WIN_LEN:   cfg_prdata = {{(32 - WIN_LEN_W){1'b0}}, win_len_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign read_index = in_tdata[16:8];
  assign byte_addr  = {1'b0, win_start_r} + {1'b0, read_index};
  assign rd_oow     = ({1'b0, read_index} >= win_len_r) ||
                      ({1'b0, byte_addr} >= SUM_W'(MAP_BYTES));

  efpmd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (op_t'(in_tuser)),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  efpmd_parser #(
    .SECTIONS   (SECTIONS),
    .PHYS_BYTES (PHYS_BYTES),
    .IDX_W      (IDX_W)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .phys_byte   (in_tdata[7:0]),
    .wr_en       (wr_en),
    .wr_idx      (wr_idx),
    .wr_data     (wr_data),
    .parse_ended (parse_ended)
  );

  efpmd_store #(
    .SECTIONS (SECTIONS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .rd_idx    (byte_addr[IDX_W:1]),
    .rd_hi     (byte_addr[0]),
    .rd_oow    (rd_oow),
    .rd_ended  (parse_ended),
    .out_data  (out_tdata),
    .out_oow   (oow_flag),
    .out_ended (ended_flag)
  );

  assign out_tuser = {ended_flag, oow_flag};

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import efpmd_pkg::*;

  localparam int MAP_SECTIONS  = SECTIONS_DEF;
  localparam int PHYS_LIMIT    = PHYS_BYTES_DEF;
  localparam int MAP_WORDS     = MAP_SECTIONS * WORDS_PER_SECTION;
  localparam int MAP_BYTES     = MAP_WORDS * 2;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_WORDS  = 1400;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       out_of_window;
    logic       parse_ended;
  } map_byte_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [23:0] in_tdata    = '0;   // phys_byte[7:0], read_index[16:8], zero[23:17]
  logic [1:0]  in_tuser    = '0;   // operation[1:0]
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;          // data[7:0]
  logic [1:0]  out_tuser;          // out_of_window[0], parse_ended[1]
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  efuse_packet_map_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [15:0] map_words [MAP_WORDS];
  phase_t      prs_phase;
  logic [6:0]  sect;
  logic [3:0]  enables;
  logic [1:0]  slot;
  logic [7:0]  low_hold;
  logic [7:0]  ext_hdr;
  logic [8:0]  consumed;
  logic [8:0]  win_start;
  logic [9:0]  win_len;

  map_byte_t   pending_reads [$];
  int          fail_count  = 0;
  int          burst_left  = 0;
  int          words_sent  = 0;
  int          cycle_count = 0;
  logic [31:0] ready_pat   = '1;
  int          ready_age   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_age == 0) begin
      ready_age = $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0: ready_pat = '1;
        1: ready_pat = $urandom | 32'h1;
        2: ready_pat = 32'h1 << $urandom_range(0, 31);
        default: ready_pat = $urandom | $urandom;
      endcase
    end
    ready_age--;
    out_tready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[31:1]};
  end

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $error("%s: expected %0h, got %0h", field, want, got);
    fail_count++;
  endtask

  always begin : result_check
    logic      taken;
    logic [7:0] got_data;
    logic [1:0] got_flags;
    map_byte_t want;
    @(negedge clk);
    taken = rst_n && (out_tvalid === 1'b1) && (out_tready === 1'b1);
    got_data = out_tdata;
    got_flags = out_tuser;
    @(posedge clk);
    if (taken) begin
      if (pending_reads.size() == 0) begin
        note_mismatch("unrequested word data", 32'd0, {24'd0, got_data});
      end else begin
        want = pending_reads.pop_front();
        if (got_data !== want.data)
          note_mismatch("data", 32'(want.data), 32'(got_data));
        if (got_flags[0] !== want.out_of_window)
          note_mismatch("out_of_window", 32'(want.out_of_window), 32'(got_flags[0]));
        if (got_flags[1] !== want.parse_ended)
          note_mismatch("parse_ended", 32'(want.parse_ended), 32'(got_flags[1]));
      end
    end
  end

  task automatic clear_map();
    for (int i = 0; i < MAP_WORDS; i++) map_words[i] = WORD_ERASED;
    prs_phase = PH_HEADER;
    sect = '0;
    enables = '0;
    slot = '0;
    low_hold = '0;
    ext_hdr = '0;
    consumed = '0;
  endtask

  // The lowest slot at or above the given one whose enable bit is clear takes the next word.
  task automatic seek_enabled(input int from);
    prs_phase = PH_HEADER;
    for (int i = WORDS_PER_SECTION - 1; i >= from; i--) begin
      if (!enables[i]) begin
        slot = 2'(i);
        prs_phase = PH_LOW;
      end
    end
  endtask

  task automatic open_packet(input logic [6:0] s, input logic [3:0] en);
    sect = s;
    enables = en;
    slot = '0;
    if (s < MAP_SECTIONS) seek_enabled(0);
    else prs_phase = PH_HEADER;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    if (prs_phase == PH_ENDED) return;
    if (prs_phase == PH_HEADER && b == HDR_END) begin
      prs_phase = PH_ENDED;
      return;
    end
    case (prs_phase)
      PH_HEADER: begin
        if (b[4:0] == HDR_EXT_CODE) begin
          ext_hdr = b;
          prs_phase = PH_EXT;
        end else begin
          open_packet({3'd0, b[7:4]}, b[3:0]);
        end
      end
      PH_EXT: open_packet({b[7:4], ext_hdr[7:5]}, b[3:0]);
      PH_LOW: begin
        low_hold = b;
        prs_phase = PH_HIGH;
      end
      default: begin
        map_words[{sect[5:0], slot}] = {b, low_hold};
        seek_enabled(int'(slot) + 1);
      end
    endcase
    consumed++;
    if (consumed >= PHYS_LIMIT) prs_phase = PH_ENDED;
  endtask

  function automatic map_byte_t read_map(input logic [8:0] ridx);
    map_byte_t   r;
    logic [9:0]  addr;
    logic [15:0] w;
    addr = {1'b0, win_start} + {1'b0, ridx};
    r.parse_ended = (prs_phase == PH_ENDED);
    if ({1'b0, ridx} >= win_len || addr >= MAP_BYTES) begin
      r.data = '0;
      r.out_of_window = 1'b1;
    end else begin
      w = map_words[addr[8:1]];
      r.data = addr[0] ? w[15:8] : w[7:0];
      r.out_of_window = 1'b0;
    end
    return r;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] pbyte,
                           input logic [8:0] ridx);
    logic rdy;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, ridx, pbyte};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (rdy !== 1'b1);
    case (op)
      OP_LOAD:    parse_byte(pbyte);
      OP_READ:    pending_reads.push_back(read_map(ridx));
      OP_RESTART: clear_map();
      default: ;
    endcase
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic load_item(input logic [7:0] b);
    send_word(OP_LOAD, b, 9'($urandom_range(0, 511)));
  endtask

  task automatic read_item(input logic [8:0] ridx);
    send_word(OP_READ, 8'($urandom_range(0, 255)), ridx);
  endtask

  task automatic restart_item();
    send_word(OP_RESTART, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    logic        rdy;
    logic [31:0] rd;
    logic [31:0] held;
    settle_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_pready;
      @(posedge clk);
    end while (rdy !== 1'b1);
    if (idx == REG_WIN_START) win_start = value[8:0];
    else win_len = value[9:0];
    held = (idx == REG_WIN_START) ? {23'd0, win_start} : {22'd0, win_len};
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_pready;
      rd = cfg_prdata;
      @(posedge clk);
    end while (rdy !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== held) note_mismatch(idx == REG_WIN_START ? "window_start" : "window_length",
                                   held, rd);
  endtask

  function automatic logic [8:0] pick_read_index();
    if (win_len != 0 && $urandom_range(0, 3) != 0)
      return 9'($urandom_range(0, int'(win_len) - 1));
    return 9'($urandom_range(0, 511));
  endfunction

  task automatic maybe_read();
    if ($urandom_range(0, 4) == 0) read_item(pick_read_index());
  endtask

  // A well-formed packet: plain or extended header, then a word per clear enable bit if mapped.
  task automatic emit_packet();
    logic [6:0] sec;
    logic [3:0] en;
    logic [7:0] hdr;
    en = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0) begin
      sec = 7'($urandom_range(0, 127));
      load_item({sec[2:0], HDR_EXT_CODE});
      maybe_read();
      load_item({sec[6:3], en});
    end else begin
      hdr = {4'($urandom_range(0, 15)), en};
      if (hdr[4:0] == HDR_EXT_CODE || hdr == HDR_END) hdr[0] = 1'b0;
      sec = {3'd0, hdr[7:4]};
      en = hdr[3:0];
      load_item(hdr);
    end
    maybe_read();
    if (sec < MAP_SECTIONS) begin
      for (int i = 0; i < WORDS_PER_SECTION; i++) begin
        if (!en[i]) begin
          load_item(8'($urandom_range(0, 255)));
          maybe_read();
          load_item(8'($urandom_range(0, 255)));
          maybe_read();
        end
      end
    end
  endtask

  task automatic test_erased_map();
    read_item(9'd0);
    read_item(9'd1);
    read_item(9'd255);
    read_item(9'd511);
  endtask

  task automatic test_packet_forms();
    load_item(8'h00);
    for (int i = 0; i < 8; i++) load_item(8'(17 * i + 3));
    load_item(8'h3E);
    load_item(8'hA5);
    load_item(8'h5A);
    load_item(8'h5B);
    load_item(8'h80);
    load_item(8'h7F);
    load_item(8'h1F);
    load_item(8'h2F);
    load_item(8'hFE);
    load_item(8'hEF);
    load_item(8'hFF);
    load_item(8'hEF);
    load_item(8'h70);
    for (int i = 0; i < 8; i++) load_item(8'(8'hF0 - 29 * i));
    send_word(OP_UNUSED, 8'hFF, 9'h1FF);
    read_item(9'd0);
    read_item(9'd7);
    read_item(9'd8);
    read_item(9'd24);
    read_item(9'd25);
    read_item(9'd44);
    read_item(9'd45);
    read_item(9'd504);
    read_item(9'd511);
  endtask

  task automatic test_terminator();
    load_item(HDR_END);
    read_item(9'd0);
    load_item(8'h00);
    load_item(8'h12);
    read_item(9'd1);
    restart_item();
    read_item(9'd0);
    read_item(9'd511);
  endtask

  // Fills the physical limit so that it cuts a word in half, then so that
  // it falls on an extended header.
  task automatic test_byte_limit();
    restart_item();
    repeat (84) begin
      load_item(8'h0E);
      load_item(8'($urandom_range(0, 255)));
      load_item(8'($urandom_range(0, 255)));
    end
    load_item(8'h00);
    load_item(8'h9C);
    load_item(8'h63);
    load_item(8'h5A);
    load_item(8'hC3);
    read_item(9'd0);
    read_item(9'd1);
    read_item(9'd2);
    read_item(9'd3);
    restart_item();
    repeat (85) begin
      load_item(8'h0E);
      load_item(8'($urandom_range(0, 255)));
      load_item(8'($urandom_range(0, 255)));
    end
    load_item({3'b101, HDR_EXT_CODE});
    load_item(8'h00);
    read_item(9'd0);
    read_item(9'd8);
  endtask

  task automatic test_window_edges();
    restart_item();
    load_item(8'hEF);
    load_item(8'h77);
    load_item(8'h34);
    load_item(8'h12);
    cfg_write(REG_WIN_START, 32'd511);
    cfg_write(REG_WIN_LEN, 32'd512);
    read_item(9'd0);
    read_item(9'd1);
    read_item(9'd511);
    cfg_write(REG_WIN_START, 32'd0);
    cfg_write(REG_WIN_LEN, 32'd0);
    read_item(9'd0);
    read_item(9'd511);
    cfg_write(REG_WIN_START, 32'd100);
    cfg_write(REG_WIN_LEN, 32'd10);
    read_item(9'd9);
    read_item(9'd10);
    read_item(9'd256);
    cfg_write(REG_WIN_START, 32'd0);
    cfg_write(REG_WIN_LEN, 32'd512);
    read_item(9'd510);
    read_item(9'd511);
  endtask

  task automatic test_random_traffic();
    int start_count;
    int pick;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_WIN_START, 32'd0);
          cfg_write(REG_WIN_LEN, 32'd512);
        end
        1: begin
          cfg_write(REG_WIN_START, $urandom_range(0, 511));
          cfg_write(REG_WIN_LEN, $urandom_range(0, 512));
        end
        2: begin
          cfg_write(REG_WIN_START, 32'd511);
          cfg_write(REG_WIN_LEN, $urandom_range(0, 512));
        end
        default: begin
          cfg_write(REG_WIN_START, $urandom_range(0, 64));
          cfg_write(REG_WIN_LEN, 32'd512);
        end
      endcase
      start_count = words_sent;
      while (words_sent - start_count < RANDOM_WORDS / 4) begin
        pick = $urandom_range(0, 99);
        if (prs_phase == PH_ENDED && $urandom_range(0, 3) == 0) restart_item();
        else if (pick < 60) emit_packet();
        else if (pick < 78) repeat ($urandom_range(1, 6)) read_item(pick_read_index());
        else if (pick < 86) load_item(8'($urandom_range(0, 255)));
        else if (pick < 90) send_word(OP_UNUSED, 8'($urandom_range(0, 255)),
                                      9'($urandom_range(0, 511)));
        else if (pick < 92) load_item(HDR_END);
        else if (pick < 93) restart_item();
        else read_item(9'($urandom_range(0, 511)));
      end
    end
  endtask

  initial begin
    clear_map();
    win_start = '0;
    win_len = WIN_LEN_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_erased_map();
    test_packet_forms();
    test_terminator();
    test_byte_limit();
    test_window_edges();
    test_random_traffic();
    settle_idle();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
